### hw/rtl/kts_pkg.sv
// Shared types, constants and tables for the Kalman trajectory smoother.
// Used by kts_div and kalman_trajectory_smoother_top; depends on nothing.
`default_nettype none

package kts_pkg;

  // Default CORDIC iteration count (legal range 8 to 32).
  localparam int CORDIC_STEPS_DEF = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 8'd1;

  localparam logic [31:0] PROCESS_NOISE_RST = 32'd4294967;
  localparam logic [31:0] MEASURE_NOISE_RST = 32'd268435456;

  // Fixed-point constants; angles are radians in Q.32.
  localparam logic [31:0] ONE_Q30      = 32'd1073741824;
  localparam logic [34:0] PI_Q32       = 35'd13493037704;
  localparam logic [34:0] HALF_PI_Q32  = 35'd6746518852;
  localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
  localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;

  // Input item.
  typedef struct packed {
    logic               transform_valid;
    logic signed [31:0] mat_a00;
    logic signed [31:0] mat_a10;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [31:0] out_cos;
    logic signed [31:0] out_sin;
    logic signed [31:0] out_shift_x;
    logic signed [31:0] out_shift_y;
    logic               updated;
  } out_item_t;

  // Gain divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] pp;
    logic [32:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] quo;
  } div_rsp_t;

  // CORDIC arctangent table, round(atan(2^-i) * 2^32).
  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd3373259426;
      5'd1:  v = 32'd1991351318;
      5'd2:  v = 32'd1052175346;
      5'd3:  v = 32'd534100635;
      5'd4:  v = 32'd268086748;
      5'd5:  v = 32'd134174063;
      5'd6:  v = 32'd67103403;
      5'd7:  v = 32'd33553749;
      5'd8:  v = 32'd16777131;
      5'd9:  v = 32'd8388597;
      5'd10: v = 32'd4194303;
      default: v = 32'd2097152 >> (i - 5'd11);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/kts_div.sv
// Radix-2 restoring divider for the Kalman gain K = floor(pp * 2^30 / den).
// Uses kts_pkg for its request and response structs.
`default_nettype none

module kts_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire kts_pkg::div_req_t req,
  output kts_pkg::div_rsp_t      rsp
);
  import kts_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] den_r, den_nxt;
  logic        low_r, low_nxt;
  logic [30:0] quo_r, quo_nxt;
  logic [33:0] trial;
  logic        ge;

  // Bring down the next numerator bit: only the first one can be nonzero.
  assign trial = {rem_r, (cnt_r == 5'd30) ? low_r : 1'b0};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      quo_nxt = '0;
      if (req.den == '0) begin
        // A zero denominator gives a zero gain.
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
        cnt_nxt  = 5'd30;
        rem_nxt  = {2'b00, req.pp[31:1]};
        low_nxt  = req.pp[0];
        den_nxt  = req.den;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? 33'(trial - {1'b0, den_r}) : trial[32:0];
      quo_nxt = {quo_r[29:0], ge};
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

`default_nettype wire

### hw/rtl/kalman_trajectory_smoother_top.sv
// Kalman trajectory smoother for video stabilization: top level.
// Depends on kts_pkg and kts_div.
//
// One item is processed at a time; the input stalls until its result is
// loaded into the output register. A shared CORDIC stage runs atan2 and
// later sin/cos one iteration per cycle, a 31-iteration restoring divider
// forms each of the three Kalman gains, one shared 32x32 multiplier serves
// three products per axis, and a 16-step subtract loop reduces the
// corrected angle modulo 2*pi. A zero transform vector skips the atan2
// iterations. An invalid item goes straight to the output state and
// re-sends the held result. Configuration writes are always ready.
`default_nettype none

module kalman_trajectory_smoother_top #(
  parameter int CORDIC_STEPS = kts_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire kts_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output kts_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [kts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                       cfg_data
);
  import kts_pkg::*;

  localparam int XW = 36;   // CORDIC datapath width
  localparam int AW = 51;   // corrected angle width

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AT0  = 4'd1;
  localparam logic [3:0] S_ATC  = 4'd2;
  localparam logic [3:0] S_SUM  = 4'd3;
  localparam logic [3:0] S_KP   = 4'd4;
  localparam logic [3:0] S_KD   = 4'd5;
  localparam logic [3:0] S_KM1  = 4'd6;
  localparam logic [3:0] S_KM2  = 4'd7;
  localparam logic [3:0] S_KM3  = 4'd8;
  localparam logic [3:0] S_KM4  = 4'd9;
  localparam logic [3:0] S_COR  = 4'd10;
  localparam logic [3:0] S_RED  = 4'd11;
  localparam logic [3:0] S_FOLD = 4'd12;
  localparam logic [3:0] S_ROT  = 4'd13;
  localparam logic [3:0] S_FIN  = 4'd14;
  localparam logic [3:0] S_OUT  = 4'd15;

  localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

  // Saturate to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [52:0] v);
    logic signed [47:0] r;
    if (v > 53'sd140737488355327)       r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -53'sd140737488355328) r = 48'sh8000_0000_0000;
    else                                r = v[47:0];
    return r;
  endfunction

  // Saturate to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [XW-1:0] v);
    logic signed [31:0] r;
    if (v > XW'(64'sd2147483647))       r = 32'sh7FFF_FFFF;
    else if (v < -XW'(64'sd2147483648)) r = 32'sh8000_0000;
    else                                r = v[31:0];
    return r;
  endfunction

  // Corrected shift in Q16.32 rounded to Q16.16 and saturated.
  function automatic logic signed [31:0] to_q16(input logic signed [47:0] dsh,
                                                input logic signed [47:0] est,
                                                input logic signed [47:0] sum);
    logic signed [49:0] d;
    logic signed [33:0] t;
    logic signed [31:0] r;
    d = 50'(dsh) + 50'(est) - 50'(sum) + 50'sd32768;
    t = 34'(d >>> 16);
    if (t > 34'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (t < -34'sd2147483648) r = 32'sh8000_0000;
    else                           r = t[31:0];
    return r;
  endfunction

  // Control and configuration.
  logic [3:0]  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic        upd_r, upd_nxt;
  logic        fold_r, fold_nxt;
  logic        red_neg_r, red_neg_nxt;
  logic [31:0] q_r, r_r;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;

  // Filter state.
  logic signed [47:0] sum_r [3];
  logic signed [47:0] sum_nxt [3];
  logic signed [47:0] est_r [3];
  logic signed [47:0] est_nxt [3];
  logic [31:0]        var_r [3];
  logic [31:0]        var_nxt [3];
  logic signed [31:0] held_cos_r, held_cos_nxt, held_sin_r, held_sin_nxt;
  logic signed [31:0] held_sx_r, held_sx_nxt, held_sy_r, held_sy_nxt;

  // Working registers.
  logic signed [47:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [XW-1:0] da_r, da_nxt;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [31:0]          pp_r, pp_nxt;
  logic [30:0]          k_r, k_nxt;
  logic [48:0]          dmag_r, dmag_nxt;
  logic                 dneg_r, dneg_nxt;
  logic [63:0]          prod_r, prod_nxt, acc_r, acc_nxt;
  logic [AW-2:0]        amag_r, amag_nxt;

  // Shared units.
  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [31:0] mul_a, mul_b;
  logic                 cdir;
  logic signed [XW-1:0] sx, sy, tab;
  logic signed [XW-1:0] cx_n, cy_n, cz_n;

  kts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared CORDIC stage: vectoring while in S_ATC, rotation otherwise.
  assign cdir = (state_r == S_ATC) ? y_r[XW-1] : !z_r[XW-1];
  assign sx   = x_r >>> cnt_r;
  assign sy   = y_r >>> cnt_r;
  assign tab  = $signed({{(XW-32){1'b0}}, atan_q32(cnt_r)});
  assign cx_n = cdir ? x_r - sy : x_r + sy;
  assign cy_n = cdir ? y_r + sx : y_r - sx;
  assign cz_n = cdir ? z_r - tab : z_r + tab;

  // Shared multiplier operand selection.
  always_comb begin
    case (state_r)
      S_KM1:   begin mul_a = {13'd0, dmag_r[48:30]}; mul_b = {1'b0, k_r}; end
      S_KM2:   begin mul_a = {2'd0, dmag_r[29:0]};   mul_b = {1'b0, k_r}; end
      S_KM3:   begin mul_a = ONE_Q30 - {1'b0, k_r};  mul_b = pp_r;        end
      default: begin mul_a = '0;                     mul_b = '0;          end
    endcase
  end

  // Sequencer and datapath.
  always_comb begin
    logic [32:0]        pp_s;
    logic [31:0]        pp_c;
    logic signed [48:0] dd;
    logic [50:0]        pmag;
    logic signed [52:0] pv;
    logic signed [AW-1:0] ang;
    logic [AW-2:0]      red_cmp;
    logic signed [XW:0] rr;

    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    ax_nxt       = ax_r;
    upd_nxt      = upd_r;
    fold_nxt     = fold_r;
    red_neg_nxt  = red_neg_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;
    sum_nxt      = sum_r;
    est_nxt      = est_r;
    var_nxt      = var_r;
    held_cos_nxt = held_cos_r;
    held_sin_nxt = held_sin_r;
    held_sx_nxt  = held_sx_r;
    held_sy_nxt  = held_sy_r;
    dx_nxt       = dx_r;
    dy_nxt       = dy_r;
    da_nxt       = da_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    pp_nxt       = pp_r;
    k_nxt        = k_r;
    dmag_nxt     = dmag_r;
    dneg_nxt     = dneg_r;
    prod_nxt     = prod_r;
    acc_nxt      = acc_r;
    amag_nxt     = amag_r;
    div_req      = '0;
    pp_s         = '0;
    pp_c         = '0;
    dd           = '0;
    pmag         = '0;
    pv           = '0;
    ang          = '0;
    rr           = '0;
    red_cmp      = (AW-1)'({TWO_PI_Q32, 15'd0} >> (5'd15 - {1'b0, cnt_r[3:0]}));

    case (state_r)
      // Take one item; an invalid one goes straight to the output.
      S_IDLE: begin
        if (in_valid) begin
          upd_nxt = in_data.transform_valid;
          dx_nxt  = {in_data.shift_x, 16'd0};
          dy_nxt  = {in_data.shift_y, 16'd0};
          x_nxt   = XW'(in_data.mat_a00);
          y_nxt   = XW'(in_data.mat_a10);
          z_nxt   = '0;
          state_nxt = in_data.transform_valid ? S_AT0 : S_OUT;
        end
      end
      // Zero vector and left half-plane handling before atan2 iterations.
      S_AT0: begin
        cnt_nxt = '0;
        if (x_r == '0 && y_r == '0) begin
          da_nxt    = '0;
          state_nxt = S_SUM;
        end else begin
          if (x_r[XW-1]) begin
            z_nxt = y_r[XW-1] ? -$signed({1'b0, PI_Q32}) : $signed({1'b0, PI_Q32});
            x_nxt = -x_r;
            y_nxt = -y_r;
          end
          state_nxt = S_ATC;
        end
      end
      // atan2 iterations.
      S_ATC: begin
        x_nxt = cx_n;
        y_nxt = cy_n;
        z_nxt = cz_n;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          da_nxt    = cz_n;
          state_nxt = S_SUM;
        end
      end
      // Accumulate the trajectory.
      S_SUM: begin
        sum_nxt[0] = sat48(53'(sum_r[0]) + 53'(dx_r));
        sum_nxt[1] = sat48(53'(sum_r[1]) + 53'(dy_r));
        sum_nxt[2] = sat48(53'(sum_r[2]) + 53'(da_r));
        ax_nxt     = 2'd0;
        state_nxt  = S_KP;
      end
      // Predict and launch the gain division.
      S_KP: begin
        pp_s = {1'b0, var_r[ax_r]} + {1'b0, q_r};
        pp_c = pp_s[32] ? 32'hFFFF_FFFF : pp_s[31:0];
        pp_nxt = pp_c;
        div_req.start = 1'b1;
        div_req.pp    = pp_c;
        div_req.den   = {1'b0, pp_c} + {1'b0, r_r};
        dd = 49'(sum_r[ax_r]) - 49'(est_r[ax_r]);
        dneg_nxt = dd[48];
        dmag_nxt = dd[48] ? 49'(-dd) : 49'(dd);
        state_nxt = S_KD;
      end
      S_KD: begin
        if (div_rsp.done) begin
          k_nxt     = div_rsp.quo;
          state_nxt = S_KM1;
        end
      end
      S_KM1: begin
        prod_nxt  = 64'(mul_a) * 64'(mul_b);
        state_nxt = S_KM2;
      end
      S_KM2: begin
        acc_nxt   = prod_r;
        prod_nxt  = 64'(mul_a) * 64'(mul_b);
        state_nxt = S_KM3;
      end
      // Update the estimate, then the variance product.
      S_KM3: begin
        pmag = 51'(acc_r) + 51'(prod_r >> 30);
        pv   = dneg_r ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag});
        est_nxt[ax_r] = sat48(53'(est_r[ax_r]) + pv);
        prod_nxt  = 64'(mul_a) * 64'(mul_b);
        state_nxt = S_KM4;
      end
      S_KM4: begin
        var_nxt[ax_r] = prod_r[61:30];
        if (ax_r == 2'd2) begin
          state_nxt = S_COR;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_KP;
        end
      end
      // Corrected motion.
      S_COR: begin
        held_sx_nxt = to_q16(dx_r, est_r[0], sum_r[0]);
        held_sy_nxt = to_q16(dy_r, est_r[1], sum_r[1]);
        ang = AW'(da_r) + AW'(est_r[2]) - AW'(sum_r[2]);
        red_neg_nxt = ang[AW-1];
        amag_nxt    = ang[AW-1] ? (AW-1)'(-ang) : ang[AW-2:0];
        cnt_nxt     = 5'd15;
        state_nxt   = S_RED;
      end
      // Magnitude modulo 2*pi, one multiple a cycle.
      S_RED: begin
        if (amag_r >= red_cmp) begin
          amag_nxt = amag_r - red_cmp;
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_FOLD;
        end
      end
      // Wrap into [-pi, pi] and fold into [-pi/2, pi/2].
      S_FOLD: begin
        rr = red_neg_r ? -$signed((XW+1)'(amag_r)) : $signed((XW+1)'(amag_r));
        if (rr > $signed((XW+1)'(PI_Q32))) begin
          rr = rr - $signed((XW+1)'(TWO_PI_Q32));
        end
        if (rr < -$signed((XW+1)'(PI_Q32))) begin
          rr = rr + $signed((XW+1)'(TWO_PI_Q32));
        end
        fold_nxt = 1'b0;
        if (rr > $signed((XW+1)'(HALF_PI_Q32))) begin
          rr = rr - $signed((XW+1)'(PI_Q32));
          fold_nxt = 1'b1;
        end else if (rr < -$signed((XW+1)'(HALF_PI_Q32))) begin
          rr = rr + $signed((XW+1)'(PI_Q32));
          fold_nxt = 1'b1;
        end
        z_nxt     = rr[XW-1:0];
        x_nxt     = XW'(INV_GAIN_Q30);
        y_nxt     = '0;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      // sin/cos rotation iterations.
      S_ROT: begin
        x_nxt = cx_n;
        y_nxt = cy_n;
        z_nxt = cz_n;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        held_cos_nxt = sat32(fold_r ? -x_r : x_r);
        held_sin_nxt = sat32(fold_r ? -y_r : y_r);
        state_nxt    = S_OUT;
      end
      // Load the output register once it is free.
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.out_cos     = held_cos_r;
          out_data_nxt.out_sin     = held_sin_r;
          out_data_nxt.out_shift_x = held_sx_r;
          out_data_nxt.out_shift_y = held_sy_r;
          out_data_nxt.updated     = upd_r;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration, control, filter state and held result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      q_r         <= PROCESS_NOISE_RST;
      r_r         <= MEASURE_NOISE_RST;
      held_cos_r  <= '0;
      held_sin_r  <= '0;
      held_sx_r   <= '0;
      held_sy_r   <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        est_r[i] <= '0;
        var_r[i] <= ONE_Q30;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      held_cos_r  <= held_cos_nxt;
      held_sin_r  <= held_sin_nxt;
      held_sx_r   <= held_sx_nxt;
      held_sy_r   <= held_sy_nxt;
      sum_r       <= sum_nxt;
      est_r       <= est_nxt;
      var_r       <= var_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PROCESS_NOISE) begin
          q_r <= cfg_data;
        end else if (cfg_index == CFG_MEASURE_NOISE) begin
          r_r <= cfg_data;
        end
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    ax_r       <= ax_nxt;
    upd_r      <= upd_nxt;
    fold_r     <= fold_nxt;
    red_neg_r  <= red_neg_nxt;
    out_data_r <= out_data_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    da_r       <= da_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    pp_r       <= pp_nxt;
    k_r        <= k_nxt;
    dmag_r     <= dmag_nxt;
    dneg_r     <= dneg_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    amag_r     <= amag_nxt;
  end

endmodule

`default_nettype wire

### tb/sv/kalman_trajectory_smoother_top_tb.sv
// Self-checking testbench for kalman_trajectory_smoother_top.
// Depends on kts_pkg and the smoother RTL.
// A bit-exact predictor follows every accepted transfer.
`default_nettype none

module kalman_trajectory_smoother_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kts_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX = 8'hFF;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -64'sh0000_7FFF_FFFF_FFFF - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;
  localparam longint PI_L = 64'sd13493037704;
  localparam longint HPI_L = 64'sd6746518852;
  localparam longint TPI_L = 64'sd26986075409;
  localparam int STEPS = CORDIC_STEPS_DEF;
  localparam longint ARC_TAB [0:31] = '{
    64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2};

  typedef struct packed {
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          val;
  } reg_write_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  kalman_trajectory_smoother_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  in_item_t   frame_q[$];
  reg_write_t reg_q[$];
  out_item_t  motion_q[$];
  int mismatches = 0;
  int unexpected = 0;
  longint cycles = 0;

  // Predictor state.
  logic [31:0] q_noise, r_noise;
  longint trk_sum [3];
  longint trk_est [3];
  logic [31:0] trk_var [3];
  out_item_t held;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint cordic_angle(longint y, longint x);
    longint z = 0;
    longint nx, ny;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARC_TAB[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARC_TAB[i];
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  // Cosine and sine of a Q.32 angle, Q2.30 results.
  function automatic void cordic_rotate(longint a, output longint c, output longint s);
    longint x = 652032874, y = 0, r, nx, ny;
    bit flip = 0;
    r = a % TPI_L;
    if (r > PI_L) r -= TPI_L;
    if (r < -PI_L) r += TPI_L;
    if (r > HPI_L) begin
      r -= PI_L; flip = 1;
    end else if (r < -HPI_L) begin
      r += PI_L; flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); r -= ARC_TAB[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); r += ARC_TAB[i];
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(x, I32_MIN, I32_MAX);
    s = clip(y, I32_MIN, I32_MAX);
  endfunction

  // One scalar filter step on axis ax with measurement z.
  function automatic void filter_axis(int ax, longint z);
    longint unsigned pp, den, k, m, p;
    longint d;
    pp = 64'(trk_var[ax]) + 64'(q_noise);
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    den = pp + 64'(r_noise);
    k = (den != 0) ? (pp << 30) / den : 0;
    d = z - trk_est[ax];
    m = d < 0 ? -d : d;
    p = (m >> 30) * k + (((m & 64'h3FFF_FFFF) * k) >> 30);
    trk_est[ax] = clip(trk_est[ax] + (d < 0 ? -longint'(p) : longint'(p)), S48_MIN, S48_MAX);
    trk_var[ax] = 32'(((64'd1073741824 - k) * pp) >> 30);
  endfunction

  function automatic longint to_pixels(longint d);
    return clip((d + 32768) >>> 16, I32_MIN, I32_MAX);
  endfunction

  function automatic out_item_t predict_motion(in_item_t it);
    longint dz [3];
    longint c, s;
    if (it.transform_valid) begin
      dz[0] = longint'(it.shift_x) * 65536;
      dz[1] = longint'(it.shift_y) * 65536;
      dz[2] = cordic_angle(longint'(it.mat_a10), longint'(it.mat_a00));
      for (int ax = 0; ax < 3; ax++)
        trk_sum[ax] = clip(trk_sum[ax] + dz[ax], S48_MIN, S48_MAX);
      for (int ax = 0; ax < 3; ax++) begin
        filter_axis(ax, trk_sum[ax]);
        dz[ax] += trk_est[ax] - trk_sum[ax];
      end
      cordic_rotate(dz[2], c, s);
      held.out_cos = 32'(c);
      held.out_sin = 32'(s);
      held.out_shift_x = 32'(to_pixels(dz[0]));
      held.out_shift_y = 32'(to_pixels(dz[1]));
      held.updated = 1'b1;
      return held;
    end
    predict_motion = held;
    predict_motion.updated = 1'b0;
  endfunction

  // Random idling, with a quiet stretch in every fourth window.
  function automatic bit idle_now();
    if ((cycles / 20000) % 4 == 3) return 0;
    return $urandom_range(99) < 7;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Input driver; the predictor steps on every accepted transfer.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
      out_stall <= 0;
      for (int ax = 0; ax < 3; ax++) begin
        trk_sum[ax] = 0; trk_est[ax] = 0; trk_var[ax] = ONE_Q30;
      end
      held = '0;
    end else begin
      if (in_valid && !in_stall) motion_q.push_back(predict_motion(in_data));
      if (!in_valid || !in_stall) begin
        if (frame_q.size() > 0 && !idle_now()) begin
          in_valid <= 1;
          in_data <= frame_q.pop_front();
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= idle_now();
    end
  end

  // Configuration driver; writes are applied to the predictor on transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_valid <= 0;
      cfg_index <= '0;
      cfg_data <= '0;
      q_noise <= PROCESS_NOISE_RST;
      r_noise <= MEASURE_NOISE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_PROCESS_NOISE) q_noise <= cfg_data;
        else if (cfg_index == CFG_MEASURE_NOISE) r_noise <= cfg_data;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_q.size() > 0) begin
          reg_write_t w;
          w = reg_q.pop_front();
          cfg_valid <= 1;
          cfg_index <= w.idx;
          cfg_data <= w.val;
        end else begin
          cfg_valid <= 0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (motion_q.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t want;
        want = motion_q.pop_front();
        if (want !== out_data) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  function automatic in_item_t make_frame();
    in_item_t it;
    int sel;
    sel = $urandom_range(99);
    it.transform_valid = sel >= 12;
    it.mat_a00 = $urandom;
    it.mat_a10 = $urandom;
    it.shift_x = $urandom;
    it.shift_y = $urandom;
    if (sel >= 30) begin
      // Near-identity similarity transforms, some turned by a half turn, and modest shifts.
      it.mat_a00 = 32'sd1073741824 - $signed(32'($urandom_range(4000000)));
      it.mat_a10 = $signed(32'($urandom_range(200000000))) - 32'sd100000000;
      if (sel >= 90) it.mat_a00 = -it.mat_a00;
      it.shift_x = $signed(32'($urandom_range(4000000))) - 32'sd2000000;
      it.shift_y = $signed(32'($urandom_range(4000000))) - 32'sd2000000;
    end
    return it;
  endfunction

  task automatic run_phase(logic [31:0] q, logic [31:0] r, int n);
    reg_q.push_back('{CFG_PROCESS_NOISE, q});
    reg_q.push_back('{CFG_MEASURE_NOISE, r});
    wait (reg_q.size() == 0 && !cfg_valid);
    repeat (n) frame_q.push_back(make_frame());
    wait (frame_q.size() == 0 && !in_valid && motion_q.size() == 0);
    repeat (250) @(posedge clk);
  endtask

  initial begin
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Writes to unmapped indexes are ignored.
    reg_q.push_back('{CFG_UNUSED_IDX, 32'hFFFF_FFFF});
    reg_q.push_back('{CFG_TOP_IDX, 32'h0});
    wait (reg_q.size() == 0 && !cfg_valid);

    // Directed: extremes, zero vector, negative cosine term, invalid items.
    frame_q.push_back('{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    frame_q.push_back('{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0});
    frame_q.push_back('{1'b1, -32'sd1073741824, 32'sd0, 32'sd65536, -32'sd65536});
    frame_q.push_back('{1'b1, -32'sd1073741824, -32'sd1, 32'sd1, -32'sd1});
    frame_q.push_back('{1'b1, 32'sd0, 32'sd1073741824, 32'sd0, 32'sd0});
    frame_q.push_back('{1'b1, 32'sd0, -32'sd1073741824, 32'sd0, 32'sd0});
    frame_q.push_back('{1'b0, 32'sd5, 32'sd5, 32'sd5, 32'sd5});
    frame_q.push_back('{1'b1, -32'sd2147483648, -32'sd2147483648,
                        -32'sd2147483648, -32'sd2147483648});
    frame_q.push_back('{1'b1, 32'sd2147483647, 32'sd2147483647,
                        32'sd2147483647, 32'sd2147483647});
    // Drive the trajectory sums into saturation both ways.
    repeat (5) frame_q.push_back('{1'b1, -32'sd1, 32'sd2147483647,
                                   32'sd2147483647, -32'sd2147483648});
    repeat (5) frame_q.push_back('{1'b1, -32'sd1, -32'sd2147483647,
                                   -32'sd2147483648, 32'sd2147483647});
    frame_q.push_back('{1'b0, -32'sd1, -32'sd1, -32'sd1, -32'sd1});
    wait (frame_q.size() == 0 && !in_valid && motion_q.size() == 0 && reg_q.size() == 0);
    repeat (250) @(posedge clk);

    run_phase(PROCESS_NOISE_RST, MEASURE_NOISE_RST, 500);
    run_phase(32'h0, 32'h0, 150);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150);
    run_phase(32'h0, 32'hFFFF_FFFF, 200);
    run_phase(32'hFFFF_FFFF, 32'h0, 150);
    run_phase($urandom, $urandom, 200);
    run_phase($urandom_range(1 << 24), $urandom_range(1 << 30), 250);

    if (mismatches == 0 && unexpected == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #15ms;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
hw/rtl/kts_pkg.sv
hw/rtl/kts_div.sv
hw/rtl/kalman_trajectory_smoother_top.sv
tb/sv/kalman_trajectory_smoother_top_tb.sv
